// File: sv/tsst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsst_pkg;

    localparam int KEY_W       = 64;
    localparam int SCORE_W     = 32;
    localparam int ENTRIES_DEF = 256;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_RECORD = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HAND
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic finish;
    } t_status;

endpackage

`default_nettype wire

// File: sv/tsst_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tsst_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 operation;
    logic [tsst_pkg::KEY_W-1:0]           key;
    logic                                 own_side;
    logic signed [tsst_pkg::SCORE_W-1:0]  score;

    modport source (output valid, output operation, output key, output own_side,
                    output score, input ready);
    modport sink   (input valid, input operation, input key, input own_side,
                    input score, output ready);
endinterface

`default_nettype wire

// File: sv/tsst_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tsst_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tsst_pkg::SCORE_W-1:0]  found_score;
    logic                                 table_full;

    modport source (output valid, output found_score, output table_full, input ready);
    modport sink   (input valid, input found_score, input table_full, output ready);
endinterface

`default_nettype wire

// File: sv/tsst_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tsst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: sv/tsst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tsst_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output tsst_pkg::t_cmd         o_cmd,
    input  wire tsst_pkg::t_status i_status
);

    tsst_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tsst_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            tsst_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = tsst_pkg::ST_SCAN;
                end
            end
            tsst_pkg::ST_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_status.finish) begin
                    n_state = tsst_pkg::ST_HAND;
                end
            end
            tsst_pkg::ST_HAND: begin
                // move the result into the output register once it is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_state       = tsst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tsst_pkg::ST_IDLE;
            end
        endcase

        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: sv/tsst_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module tsst_dp #(
    parameter int ENTRIES = tsst_pkg::ENTRIES_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire tsst_pkg::t_cmd                      i_cmd,
    output tsst_pkg::t_status                        o_status,
    input  wire logic                                i_operation,
    input  wire logic [tsst_pkg::KEY_W-1:0]          i_key,
    input  wire logic                                i_own_side,
    input  wire logic signed [tsst_pkg::SCORE_W-1:0] i_score,
    output logic signed [tsst_pkg::SCORE_W-1:0]      o_found_score,
    output logic                                     o_table_full
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int KW = tsst_pkg::KEY_W;
    localparam int SW = tsst_pkg::SCORE_W;

    // item under work
    tsst_pkg::t_op       r_op;
    logic [KW-1:0]       r_key;
    logic                r_own;
    logic signed [SW-1:0] r_score;

    // scan control; rows at or above r_fill are empty
    logic [CW-1:0]       r_next;
    logic [CW-1:0]       r_fill;
    logic                r_rd_valid;
    logic [AW-1:0]       r_rd_row;

    logic signed [SW-1:0] r_res_found, n_res_found;
    logic                 r_res_full, n_res_full;
    logic signed [SW-1:0] r_out_found;
    logic                 r_out_full;

    logic [KW-1:0] key_q;
    logic [SW-1:0] own_q;
    logic [SW-1:0] rival_q;
    logic [SW-1:0] slot;

    logic key_hit, lookup_hit, update_hit, hit, at_end, issue, tail;
    logic is_full, claim, valid_record;
    logic [AW-1:0] wr_addr;
    logic          own_we, rival_we;
    logic [SW-1:0] own_wd, rival_wd;

    always_comb begin
        slot         = r_own ? own_q : rival_q;
        key_hit      = r_rd_valid && (key_q == r_key);
        lookup_hit   = (r_op == tsst_pkg::OP_LOOKUP) && key_hit && (slot != '0);
        update_hit   = (r_op == tsst_pkg::OP_RECORD) && key_hit && (slot == '0)
                       && (r_score != '0);
        hit          = lookup_hit || update_hit;
        at_end       = (r_next == r_fill);
        issue        = i_cmd.step && !hit && !at_end;
        tail         = i_cmd.step && !hit && at_end;
        is_full      = (r_fill == CW'(ENTRIES));
        valid_record = (r_op == tsst_pkg::OP_RECORD) && (r_key != '0);
        claim        = tail && valid_record && !is_full && (r_score != '0);

        o_status.finish = i_cmd.step && (hit || at_end);

        n_res_found = lookup_hit ? slot : '0;
        n_res_full  = tail && valid_record && is_full;

        // a claimed row gets both score slots so the other side reads as zero
        wr_addr  = update_hit ? r_rd_row : r_fill[AW-1:0];
        own_we   = claim || (update_hit && r_own);
        rival_we = claim || (update_hit && !r_own);
        own_wd   = r_own ? r_score : '0;
        rival_wd = r_own ? '0 : r_score;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_rd_valid <= 1'b0;
            r_next     <= '0;
        end else begin
            if (i_cmd.load) begin
                r_next     <= '0;
                r_rd_valid <= 1'b0;
            end else if (i_cmd.step) begin
                r_next     <= issue ? r_next + CW'(1) : r_next;
                r_rd_valid <= issue;
            end else begin
                r_rd_valid <= 1'b0;
            end
            if (claim) begin
                r_fill <= r_fill + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= tsst_pkg::t_op'(i_operation);
            r_key   <= i_key;
            r_own   <= i_own_side;
            r_score <= i_score;
        end
        r_rd_row <= r_next[AW-1:0];
        if (o_status.finish) begin
            r_res_found <= n_res_found;
            r_res_full  <= n_res_full;
        end
        if (i_cmd.publish) begin
            r_out_found <= r_res_found;
            r_out_full  <= r_res_full;
        end
    end

    tsst_ram #(.WIDTH(KW), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk    (i_clk),
        .i_we     (claim),
        .i_wr_addr(r_fill[AW-1:0]),
        .i_wr_data(r_key),
        .i_rd_addr(r_next[AW-1:0]),
        .o_rd_data(key_q)
    );

    tsst_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_own_ram (
        .i_clk    (i_clk),
        .i_we     (own_we),
        .i_wr_addr(wr_addr),
        .i_wr_data(own_wd),
        .i_rd_addr(r_next[AW-1:0]),
        .o_rd_data(own_q)
    );

    tsst_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_rival_ram (
        .i_clk    (i_clk),
        .i_we     (rival_we),
        .i_wr_addr(wr_addr),
        .i_wr_data(rival_wd),
        .i_rd_addr(r_next[AW-1:0]),
        .o_rd_data(rival_q)
    );

    assign o_found_score = r_out_found;
    assign o_table_full  = r_out_full;

endmodule

`default_nettype wire

// File: sv/two_sided_score_table_scan.sv
// Flow: a transferred item scans the filled rows in order from row 0 and stops at the
// first hit or at the fill count, so a scan covers at most ENTRIES rows.
// Throughput: one item at a time, one table row read per cycle from the key/score RAMs;
// the next transfer can be taken in the cycle after the result is published; a finished
// result may wait while the next scans.
// Reset: rows fill in order, so a fill count cleared by reset marks the whole table
// empty at once; there is no clearing pass and the RAMs hold no reset value.
`timescale 1ns / 1ps
`default_nettype none

module two_sided_score_table_scan #(
    parameter int ENTRIES = tsst_pkg::ENTRIES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tsst_req_if.sink   i_req,
    tsst_rsp_if.source o_rsp
);

    tsst_pkg::t_cmd    cmd;
    tsst_pkg::t_status status;

    tsst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .o_out_valid(o_rsp.valid),
        .i_out_ready(o_rsp.ready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    tsst_dp #(.ENTRIES(ENTRIES)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_operation  (i_req.operation),
        .i_key        (i_req.key),
        .i_own_side   (i_req.own_side),
        .i_score      (i_req.score),
        .o_found_score(o_rsp.found_score),
        .o_table_full (o_rsp.table_full)
    );

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int ENTRIES     = tsst_pkg::ENTRIES_DEF;
    localparam int KEY_W       = tsst_pkg::KEY_W;
    localparam int SCORE_W     = tsst_pkg::SCORE_W;
    localparam int STALL_LIMIT = 20 * (ENTRIES + 3);
    localparam int POOL_SIZE   = 40;

    typedef struct {
        tsst_pkg::t_op             op;
        logic signed [SCORE_W-1:0] found_score;
        logic                      table_full;
    } t_reply;

    logic i_clk;
    logic i_rst_n;

    tsst_req_if req_if ();
    tsst_rsp_if rsp_if ();

    two_sided_score_table_scan #(
        .ENTRIES(ENTRIES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // shadow copy of the score table
    logic        [KEY_W-1:0]   tbl_key   [ENTRIES];
    logic signed [SCORE_W-1:0] tbl_own   [ENTRIES];
    logic signed [SCORE_W-1:0] tbl_rival [ENTRIES];

    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    t_reply           expected_replies [$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;
    int idle_cycles;
    int n_lookups;
    int n_records;
    int n_hits;
    int n_full;
    int n_replies;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on reply %0d: %s got %h expected %h", n_replies, what, got, want);
        mismatch_count++;
    endtask

    task automatic predict_reply(input tsst_pkg::t_op op, input logic [KEY_W-1:0] key,
                                 input logic side, input logic signed [SCORE_W-1:0] score,
                                 output t_reply rep);
        logic                      settled;
        logic signed [SCORE_W-1:0] slot;
        rep.op          = op;
        rep.found_score = '0;
        rep.table_full  = 1'b0;
        settled         = 1'b0;
        // key zero never matches and is never stored
        if (key != '0) begin
            if (op == tsst_pkg::OP_LOOKUP) begin
                for (int row = 0; row < ENTRIES; row++) begin
                    slot = side ? tbl_own[row] : tbl_rival[row];
                    if (tbl_key[row] == key && slot != 0) begin
                        rep.found_score = slot;
                        break;
                    end
                end
            end else begin
                for (int row = 0; row < ENTRIES && !settled; row++) begin
                    slot = side ? tbl_own[row] : tbl_rival[row];
                    if (tbl_key[row] == key) begin
                        // a taken slot is passed over
                        if (slot == 0 && score != 0) begin
                            if (side) tbl_own[row] = score;
                            else      tbl_rival[row] = score;
                            settled = 1'b1;
                        end
                    end else if (tbl_key[row] == '0) begin
                        // first empty row ends the scan even for a zero score
                        if (score != 0) begin
                            tbl_key[row] = key;
                            if (side) tbl_own[row] = score;
                            else      tbl_rival[row] = score;
                        end
                        settled = 1'b1;
                    end
                end
                rep.table_full = !settled;
            end
        end
    endtask

    function automatic logic table_has_space();
        for (int row = 0; row < ENTRIES; row++)
            if (tbl_key[row] == '0) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        k = {$urandom, $urandom};
        return (k == '0) ? 64'd1 : k;
    endfunction

    // one transfer on the request channel; prediction happens at the accepting edge
    task automatic send_item(input tsst_pkg::t_op op, input logic [KEY_W-1:0] key,
                             input logic side, input logic signed [SCORE_W-1:0] score);
        t_reply rep;
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.key       <= key;
        req_if.own_side  <= side;
        req_if.score     <= score;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predict_reply(op, key, side, score, rep);
        expected_replies.push_back(rep);
        if (op == tsst_pkg::OP_LOOKUP) n_lookups++;
        else                           n_records++;
    endtask

    task automatic wait_for_replies();
        req_if.valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_item();
        tsst_pkg::t_op             op;
        logic [KEY_W-1:0]          key;
        logic                      side;
        logic signed [SCORE_W-1:0] score;
        int                        pick;
        op   = ($urandom_range(99) < 45) ? tsst_pkg::OP_RECORD : tsst_pkg::OP_LOOKUP;
        side = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 4)      key = '0;
        else if (pick < 9) key = fresh_key();
        else               key = key_pool[$urandom_range(POOL_SIZE - 1)];
        pick = $urandom_range(99);
        if (pick < 15)      score = '0;
        else if (pick < 18) score = 32'sh7fff_ffff;
        else if (pick < 21) score = 32'sh8000_0000;
        else if (pick < 23) score = -32'sd1;
        else if (pick < 25) score = 32'sd1;
        else                score = $urandom;
        send_item(op, key, side, score);
    endtask

    task automatic test_directed();
        logic [KEY_W-1:0] ones;
        ones = '1;
        send_item(tsst_pkg::OP_LOOKUP, '0, 1'b1, 32'sd7);
        send_item(tsst_pkg::OP_LOOKUP, ones, 1'b0, '0);            // empty table misses
        send_item(tsst_pkg::OP_RECORD, '0, 1'b1, 32'sd5);          // key zero ignored
        send_item(tsst_pkg::OP_RECORD, '0, 1'b0, '0);
        send_item(tsst_pkg::OP_LOOKUP, '0, 1'b1, '0);
        send_item(tsst_pkg::OP_RECORD, ones, 1'b1, 32'sh7fff_ffff);
        send_item(tsst_pkg::OP_RECORD, ones, 1'b0, 32'sh8000_0000);
        send_item(tsst_pkg::OP_LOOKUP, ones, 1'b1, '0);
        send_item(tsst_pkg::OP_LOOKUP, ones, 1'b0, '0);
        send_item(tsst_pkg::OP_RECORD, ones, 1'b1, -32'sd1);       // slot taken: next row
        send_item(tsst_pkg::OP_LOOKUP, ones, 1'b1, '0);
        send_item(tsst_pkg::OP_RECORD, 64'd1, 1'b1, '0);           // zero score stores nothing
        send_item(tsst_pkg::OP_LOOKUP, 64'd1, 1'b1, '0);
        send_item(tsst_pkg::OP_RECORD, 64'd1, 1'b0, 32'sd1);
        send_item(tsst_pkg::OP_LOOKUP, 64'd1, 1'b1, '0);
        send_item(tsst_pkg::OP_LOOKUP, 64'd1, 1'b0, '0);
        send_item(tsst_pkg::OP_RECORD, 64'd1, 1'b0, 32'sd9);       // passes row, claims another
        send_item(tsst_pkg::OP_RECORD, 64'h8000_0000_0000_0000, 1'b0, 32'sh5555_aaaa);
        send_item(tsst_pkg::OP_RECORD, 64'h8000_0000_0000_0000, 1'b1, 32'shaaaa_5555);
        send_item(tsst_pkg::OP_LOOKUP, 64'h8000_0000_0000_0000, 1'b1, '0);
        send_item(tsst_pkg::OP_LOOKUP, 64'h8000_0000_0000_0000, 1'b0, '0);
        send_item(tsst_pkg::OP_LOOKUP, 64'h7fff_ffff_ffff_ffff, 1'b1, '0);
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_random_item();
    endtask

    task automatic test_drain_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 46;
        repeat (10) send_random_item();
        wait_for_replies();
        repeat (10) send_random_item();
    endtask

    // fill every row with new keys, then hit the full table from all sides
    task automatic test_full_table();
        logic signed [SCORE_W-1:0] score;
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        while (table_has_space()) begin
            score = $urandom;
            if (score == 0) score = 32'sd3;
            send_item(tsst_pkg::OP_RECORD, fresh_key(), 1'($urandom_range(1)), score);
        end
        send_item(tsst_pkg::OP_RECORD, fresh_key(), 1'b1, 32'sd11);
        send_item(tsst_pkg::OP_RECORD, fresh_key(), 1'b0, '0);
        repeat (40) send_random_item();
    endtask

    always @(posedge i_clk) begin : check_replies
        t_reply want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_replies.size() == 0) begin
                report_mismatch("reply with nothing pending", int'(rsp_if.found_score), 0);
            end else begin
                want = expected_replies.pop_front();
                if (rsp_if.found_score !== want.found_score)
                    report_mismatch("found_score", int'(rsp_if.found_score),
                                    int'(want.found_score));
                if (rsp_if.table_full !== want.table_full)
                    report_mismatch("table_full", int'(rsp_if.table_full),
                                    int'(want.table_full));
                if (want.found_score != 0) n_hits++;
                if (want.table_full) n_full++;
            end
            n_replies++;
        end
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.operation = 1'b0;
        req_if.key       = '0;
        req_if.own_side  = 1'b0;
        req_if.score     = '0;
        rsp_if.ready     = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        mismatch_count   = 0;
        idle_cycles      = 0;
        n_lookups        = 0;
        n_records        = 0;
        n_hits           = 0;
        n_full           = 0;
        n_replies        = 0;
        for (int row = 0; row < ENTRIES; row++) begin
            tbl_key[row]   = '0;
            tbl_own[row]   = '0;
            tbl_rival[row] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = fresh_key();
        key_pool[0] = '1;
        key_pool[1] = 64'd1;
        key_pool[2] = 64'h8000_0000_0000_0000;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phase(0, 0, 120);
        test_random_phase(46, 0, 120);
        test_random_phase(0, 46, 120);
        test_random_phase(28, 28, 120);
        test_drain_pause();
        test_full_table();

        wait_for_replies();
        repeat (ENTRIES + 8) @(posedge i_clk);

        $display("covered %0d lookups (%0d hits) and %0d records (%0d hit a full table)",
                 n_lookups, n_hits, n_records, n_full);
        $display("%0d replies checked, %0d mismatches", n_replies, mismatch_count);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
